// ----- src/pal_pkg.sv -----
// Types and codes shared by the positional array list.
package pal_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_REPLACE = 3'd3,
    ACT_SEARCH  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_BADPOS  = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  typedef struct packed {
    action_e            action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] match_position;
    logic [4:0] entry_count;
    logic       last;
  } rsp_t;

endpackage

// ----- src/positional_array_list.sv -----
// Positional array list: ordered list of signed 32-bit values with a sequencer.
//
// Usage:
//   Present a request on req_i with start_i high; it is taken at a rising
//   edge where busy_o is low. Each result transaction appears on rsp_o for
//   exactly one cycle with valid_o high, in the cycle after the step that
//   makes it. The final result of a request has rsp_o.last set.
//   Append, replace, unused codes and every error finish from the idle state.
//   Insert and remove move one entry at a time, a read step then a write
//   step, through the one read port and one write port of the entry memory.
//   Search reads and compares one live entry at a time, a read step then a
//   compare step, with one result per match; the final result is made in
//   the end state that follows the scan.
//   busy_o stays high while a multi-cycle request runs; a new request may
//   be taken while the final result of the previous one is still shown.
//   Reset empties the list; the entry memory is not cleared, as slots past
//   the count are never read before they are written.
//   The receiver cannot stall: every result is taken in the cycle it shows.
module positional_array_list #(
  parameter int DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pal_pkg::req_t   req_i,
  output logic            busy_o,
  output logic            valid_o,
  output pal_pkg::rsp_t   rsp_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 5) ? CW : 5) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SH_RD  = 3'd1;
  localparam logic [2:0] S_SH_WR  = 3'd2;
  localparam logic [2:0] S_SR_RD  = 3'd3;
  localparam logic [2:0] S_SR_CMP = 3'd4;
  localparam logic [2:0] S_SR_END = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] tgt_q, tgt_d;
  logic          ins_q, ins_d;
  logic [31:0]   val_q, val_d;
  logic [4:0]    hold_pos_q, hold_pos_d;
  logic          hold_v_q, hold_v_d;
  logic          valid_q, valid_d;
  pal_pkg::rsp_t rsp_q, rsp_d;

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   wdata;

  logic          accept;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_m1;

  assign accept = start_i && (state_q == S_IDLE);
  assign pos_x  = XW'(req_i.position);
  assign cnt_x  = XW'(cnt_q);
  assign pos_m1 = pos_x - XW'(1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    tgt_d      = tgt_q;
    ins_d      = ins_q;
    val_d      = val_q;
    hold_pos_d = hold_pos_q;
    hold_v_d   = hold_v_q;
    valid_d    = 1'b0;
    rsp_d      = rsp_q;
    rsp_d.match_position = '0;
    rsp_d.last           = 1'b1;
    rsp_d.status         = pal_pkg::ST_OK;
    we    = 1'b0;
    waddr = '0;
    wdata = req_i.value;
    raddr = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          val_d   = req_i.value;
          case (req_i.action)
            pal_pkg::ACT_APPEND: begin
              if (cnt_q >= CW'(DEPTH)) begin
                rsp_d.status = pal_pkg::ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                cnt_d = cnt_q + CW'(1);
              end
            end
            pal_pkg::ACT_INSERT: begin
              if (cnt_q == '0) begin
                rsp_d.status = pal_pkg::ST_EMPTY;
              end else if (cnt_q >= CW'(DEPTH)) begin
                rsp_d.status = pal_pkg::ST_FULL;
              end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                rsp_d.status = pal_pkg::ST_BADPOS;
              end else begin
                valid_d = 1'b0;
                ins_d   = 1'b1;
                idx_d   = cnt_q;
                tgt_d   = CW'(pos_m1);
                state_d = S_SH_RD;
              end
            end
            pal_pkg::ACT_REMOVE: begin
              if (cnt_q == '0) begin
                rsp_d.status = pal_pkg::ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                rsp_d.status = pal_pkg::ST_BADPOS;
              end else begin
                valid_d = 1'b0;
                ins_d   = 1'b0;
                idx_d   = CW'(pos_m1);
                tgt_d   = cnt_q - CW'(1);
                state_d = S_SH_RD;
              end
            end
            pal_pkg::ACT_REPLACE: begin
              if (cnt_q == '0) begin
                rsp_d.status = pal_pkg::ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                rsp_d.status = pal_pkg::ST_BADPOS;
              end else begin
                we    = 1'b1;
                waddr = AW'(pos_m1);
              end
            end
            pal_pkg::ACT_SEARCH: begin
              if (cnt_q == '0) begin
                rsp_d.status = pal_pkg::ST_EMPTY;
              end else begin
                valid_d  = 1'b0;
                idx_d    = '0;
                hold_v_d = 1'b0;
                state_d  = S_SR_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SH_RD: begin
        if (idx_q == tgt_q) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          if (ins_q) begin
            we    = 1'b1;
            waddr = idx_q[AW-1:0];
            wdata = val_q;
            cnt_d = cnt_q + CW'(1);
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end else begin
          raddr   = ins_q ? AW'(idx_q - CW'(1)) : AW'(idx_q + CW'(1));
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we      = 1'b1;
        waddr   = idx_q[AW-1:0];
        wdata   = rdata_q;
        idx_d   = ins_q ? idx_q - CW'(1) : idx_q + CW'(1);
        state_d = S_SH_RD;
      end
      S_SR_RD: begin
        if (idx_q == cnt_q) begin
          state_d = S_SR_END;
        end else begin
          state_d = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        if (rdata_q == val_q) begin
          if (hold_v_q) begin
            valid_d              = 1'b1;
            rsp_d.match_position = hold_pos_q;
            rsp_d.last           = 1'b0;
          end
          hold_pos_d = 5'(idx_q + CW'(1));
          hold_v_d   = 1'b1;
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_SR_RD;
      end
      S_SR_END: begin
        valid_d  = 1'b1;
        hold_v_d = 1'b0;
        state_d  = S_IDLE;
        if (hold_v_q) begin
          rsp_d.match_position = hold_pos_q;
        end else begin
          rsp_d.status = pal_pkg::ST_NOMATCH;
        end
      end
      default: state_d = S_IDLE;
    endcase

    rsp_d.entry_count = 5'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hold_v_q <= hold_v_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    tgt_q      <= tgt_d;
    ins_q      <= ins_d;
    val_q      <= val_d;
    hold_pos_q <= hold_pos_d;
    rsp_q      <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.last) |-> !busy_o)
    else $error("final result shown while still busy");

  a_notlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !rsp_o.last) |-> busy_o)
    else $error("intermediate result shown while idle");

  a_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !hold_v_q)
    else $error("pending match left over after search");

  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.match_position != 5'd0) |-> rsp_o.status == pal_pkg::ST_OK)
    else $error("match position on a non-ok result");

endmodule
